// ===== sv/video_unit_register_interface_assert.svh =====
// Assertion macros for the video unit register interface checker.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef VIDEO_UNIT_REGISTER_INTERFACE_ASSERT_SVH
`define VIDEO_UNIT_REGISTER_INTERFACE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define VURI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vuri: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define VURI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vuri: next-cycle check failed");

`endif

// ===== sv/vuri_pkg.sv =====
// Shared types and constants for the video unit register interface.
// No dependencies; used by the controller, datapath, top level and checker.
package vuri_pkg;

    // Request kinds
    localparam logic [1:0] REQ_READ     = 2'd0;
    localparam logic [1:0] REQ_WRITE    = 2'd1;
    localparam logic [1:0] REQ_VBLANK   = 2'd2;
    localparam logic [1:0] REQ_PRERENDER = 2'd3;

    // CPU register numbers
    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_MASK    = 3'd1;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_OAMADDR = 3'd3;
    localparam logic [2:0] REG_OAMDATA = 3'd4;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDR    = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    // Storage sizes
    localparam int NAMETABLE_BYTES  = 1024;
    localparam int SPRITE_MEM_BYTES = 256;
    localparam int PATTERN_BYTES    = 8192;
    localparam int PALETTE_BYTES    = 32;
    localparam int NT_AW  = $clog2(2 * NAMETABLE_BYTES);
    localparam int SPR_AW = $clog2(SPRITE_MEM_BYTES);
    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam int PAL_AW = $clog2(PALETTE_BYTES);

    // Palette region starts here in the 14-bit bus space
    localparam logic [13:0] PALETTE_BASE = 14'h3F00;

    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] reg_addr;
        logic [7:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       nmi_pulse;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic exec;
        logic finish;
    } ctrl_cmd_t;

endpackage

// ===== sv/video_unit_register_interface.sv =====
// Top level of the video unit register interface.
// Depends on vuri_pkg, vuri_ctrl and vuri_dp.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+----------------------------
//  in      | input     | in_valid / in_ready   | in_data  (vuri_pkg::in_item_t)
//  out     | output    | out_valid / out_ready | out_data (vuri_pkg::out_item_t)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_data (mirror mode)
//
// Each item has an execute step, which issues the memory access, and a response
// step, which collects the registered read data and loads the output register.
// A result that is not taken holds the controller in its response step, so
// the next item waits until the output register frees.
// Reset clears control and architectural registers, not per-item ones or memories.
// Configuration writes are accepted in every cycle.
module video_unit_register_interface (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vuri_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vuri_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    vuri_pkg::ctrl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    vuri_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    vuri_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule

// ===== sv/vuri_ctrl.sv =====
// Sequencing controller for the video unit register interface.
// Depends on vuri_pkg for the command struct.
module vuri_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output vuri_pkg::ctrl_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // Output slot can take a new result when empty or being drained
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE) || ((state_reg == ST_RESP) && out_free);
        cmd.capture = in_valid && in_ready;
        cmd.exec    = (state_reg == ST_EXEC);
        cmd.finish  = (state_reg == ST_RESP) && out_free;
    end

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (cmd.finish)
                    state_next = cmd.capture ? ST_EXEC : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until transferred
    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/vuri_dp.sv =====
// Datapath of the video unit register interface: registers, address decode,
// sprite, pattern, nametable and palette memories. Depends on vuri_pkg.
module vuri_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  vuri_pkg::ctrl_cmd_t cmd,
    input  vuri_pkg::in_item_t  in_data,
    input  logic                cfg_valid,
    input  logic                cfg_data,
    output vuri_pkg::out_item_t out_data
);

    // Memory target of a data-port access
    localparam logic [1:0] SEL_PAT = 2'd0;
    localparam logic [1:0] SEL_NT  = 2'd1;
    localparam logic [1:0] SEL_PAL = 2'd2;

    // Where the result byte comes from
    localparam logic [1:0] KIND_VAL  = 2'd0;
    localparam logic [1:0] KIND_SPR  = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    // Architectural registers
    logic [7:0]  ctrl_reg,     ctrl_next;
    logic [7:0]  mask_reg,     mask_next;
    logic [2:0]  flags_reg,    flags_next;
    logic        toggle_reg,   toggle_next;
    logic [7:0]  rbuf_reg,     rbuf_next;
    logic [15:0] cur_reg,      cur_next;
    logic [15:0] temp_reg,     temp_next;
    logic [2:0]  finex_reg,    finex_next;
    logic [7:0]  spr_addr_reg, spr_addr_next;
    logic        mirror_reg;

    // Per-item registers
    vuri_pkg::in_item_t  item_reg;
    logic [1:0]          kind_reg,   kind_next;
    logic [7:0]          val_reg,    val_next;
    logic [1:0]          sel_reg,    sel_next;
    logic                bypass_reg, bypass_next;
    logic                nmi_reg,    nmi_next;
    vuri_pkg::out_item_t out_reg;

    // Memories and their read registers
    logic [7:0] spr_mem [vuri_pkg::SPRITE_MEM_BYTES];
    logic [7:0] pat_mem [vuri_pkg::PATTERN_BYTES];
    logic [7:0] nt_mem  [2 * vuri_pkg::NAMETABLE_BYTES];
    logic [7:0] pal_mem [vuri_pkg::PALETTE_BYTES];
    logic [7:0] spr_rd_reg;
    logic [7:0] pat_rd_reg;
    logic [7:0] nt_rd_reg;
    logic [7:0] pal_rd_reg;

    // Decode and control wires
    logic [13:0]                 bus_addr;
    logic [1:0]                  tgt;
    logic [vuri_pkg::NT_AW-1:0]  nt_idx;
    logic [vuri_pkg::PAL_AW-1:0] pal_idx;
    logic [15:0]                 step;
    logic                        data_rd;
    logic                        data_wr;
    logic                        spr_rd;
    logic                        spr_wr;
    logic [7:0]                  fetched;
    logic [7:0]                  result;

    // Map the current address onto a memory
    always_comb
    begin
        bus_addr = cur_reg[13:0];
        if (!bus_addr[13])
            tgt = SEL_PAT;
        else if (bus_addr < vuri_pkg::PALETTE_BASE)
            tgt = SEL_NT;
        else
            tgt = SEL_PAL;
        nt_idx  = {(mirror_reg ? bus_addr[11] : bus_addr[10]), bus_addr[9:0]};
        pal_idx = bus_addr[vuri_pkg::PAL_AW-1:0];
        // Sprite backdrop entries alias the background ones
        if (pal_idx[4] && (pal_idx[1:0] == 2'b00))
            pal_idx[4] = 1'b0;
        step = ctrl_reg[2] ? 16'd32 : 16'd1;
    end

    // Memory strobes during execution
    always_comb
    begin
        data_rd = cmd.exec && (item_reg.req_type == vuri_pkg::REQ_READ)
                  && (item_reg.reg_addr == vuri_pkg::REG_DATA);
        data_wr = cmd.exec && (item_reg.req_type == vuri_pkg::REQ_WRITE)
                  && (item_reg.reg_addr == vuri_pkg::REG_DATA);
        spr_rd  = cmd.exec && (item_reg.req_type == vuri_pkg::REQ_READ)
                  && (item_reg.reg_addr == vuri_pkg::REG_OAMDATA);
        spr_wr  = cmd.exec && (item_reg.req_type == vuri_pkg::REQ_WRITE)
                  && (item_reg.reg_addr == vuri_pkg::REG_OAMDATA);
    end

    // Select the fetched byte and the final result
    always_comb
    begin
        case (sel_reg)
            SEL_PAT: fetched = pat_rd_reg;
            SEL_NT:  fetched = nt_rd_reg;
            default: fetched = pal_rd_reg;
        endcase
        case (kind_reg)
            KIND_SPR:  result = spr_rd_reg;
            KIND_DATA: result = bypass_reg ? fetched : rbuf_reg;
            default:   result = val_reg;
        endcase
    end

    // Register updates for one item
    always_comb
    begin
        ctrl_next     = ctrl_reg;
        mask_next     = mask_reg;
        flags_next    = flags_reg;
        toggle_next   = toggle_reg;
        rbuf_next     = rbuf_reg;
        cur_next      = cur_reg;
        temp_next     = temp_reg;
        finex_next    = finex_reg;
        spr_addr_next = spr_addr_reg;
        kind_next     = kind_reg;
        val_next      = val_reg;
        sel_next      = sel_reg;
        bypass_next   = bypass_reg;
        nmi_next      = nmi_reg;

        if (cmd.exec)
        begin
            kind_next   = KIND_VAL;
            val_next    = 8'd0;
            nmi_next    = 1'b0;
            sel_next    = tgt;
            bypass_next = (tgt == SEL_PAL);
            case (item_reg.req_type)
                vuri_pkg::REQ_READ:
                begin
                    case (item_reg.reg_addr)
                        vuri_pkg::REG_STATUS:
                        begin
                            val_next       = {flags_reg, rbuf_reg[4:0]};
                            flags_next[2]  = 1'b0;
                            toggle_next    = 1'b0;
                        end
                        vuri_pkg::REG_OAMDATA:
                        begin
                            kind_next = KIND_SPR;
                        end
                        vuri_pkg::REG_DATA:
                        begin
                            kind_next = KIND_DATA;
                            cur_next  = cur_reg + step;
                        end
                        default:
                        begin
                            val_next = 8'd0;
                        end
                    endcase
                end
                vuri_pkg::REQ_WRITE:
                begin
                    case (item_reg.reg_addr)
                        vuri_pkg::REG_CONTROL:
                        begin
                            ctrl_next        = item_reg.write_data;
                            temp_next[11:10] = item_reg.write_data[1:0];
                        end
                        vuri_pkg::REG_MASK:
                        begin
                            mask_next = item_reg.write_data;
                        end
                        vuri_pkg::REG_OAMADDR:
                        begin
                            spr_addr_next = item_reg.write_data;
                        end
                        vuri_pkg::REG_SCROLL:
                        begin
                            if (!toggle_reg)
                            begin
                                finex_next     = item_reg.write_data[2:0];
                                temp_next[4:0] = item_reg.write_data[7:3];
                                toggle_next    = 1'b1;
                            end
                            else
                            begin
                                temp_next[14:12] = item_reg.write_data[2:0];
                                temp_next[9:5]   = item_reg.write_data[7:3];
                                toggle_next      = 1'b0;
                            end
                        end
                        vuri_pkg::REG_ADDR:
                        begin
                            if (!toggle_reg)
                            begin
                                temp_next   = {2'b00, item_reg.write_data[5:0], temp_reg[7:0]};
                                toggle_next = 1'b1;
                            end
                            else
                            begin
                                temp_next   = {temp_reg[15:8], item_reg.write_data};
                                cur_next    = {temp_reg[15:8], item_reg.write_data};
                                toggle_next = 1'b0;
                            end
                        end
                        vuri_pkg::REG_DATA:
                        begin
                            cur_next = cur_reg + step;
                        end
                        default:
                        begin
                            val_next = 8'd0;
                        end
                    endcase
                end
                vuri_pkg::REQ_VBLANK:
                begin
                    flags_next[2] = 1'b1;
                    nmi_next      = ctrl_reg[7];
                end
                default:
                begin
                    flags_next = 3'b000;
                end
            endcase
        end

        // Refill the read buffer once the fetch has landed
        if (cmd.finish && (kind_reg == KIND_DATA))
            rbuf_next = fetched;
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg     <= 8'd0;
            mask_reg     <= 8'd0;
            flags_reg    <= 3'd0;
            toggle_reg   <= 1'b0;
            rbuf_reg     <= 8'd0;
            cur_reg      <= 16'd0;
            temp_reg     <= 16'd0;
            finex_reg    <= 3'd0;
            spr_addr_reg <= 8'd0;
            mirror_reg   <= 1'b0;
        end
        else
        begin
            ctrl_reg     <= ctrl_next;
            mask_reg     <= mask_next;
            flags_reg    <= flags_next;
            toggle_reg   <= toggle_next;
            rbuf_reg     <= rbuf_next;
            cur_reg      <= cur_next;
            temp_reg     <= temp_next;
            finex_reg    <= finex_next;
            spr_addr_reg <= spr_addr_next;
            if (cfg_valid)
                mirror_reg <= cfg_data;
        end
    end

    // Per-item payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;
        kind_reg   <= kind_next;
        val_reg    <= val_next;
        sel_reg    <= sel_next;
        bypass_reg <= bypass_next;
        nmi_reg    <= nmi_next;
        if (cmd.finish)
        begin
            out_reg.read_data <= result;
            out_reg.nmi_pulse <= nmi_reg;
        end
    end

    // Sprite memory
    always_ff @(posedge clk)
    begin
        if (spr_wr)
            spr_mem[spr_addr_reg] <= item_reg.write_data;
        if (spr_rd)
            spr_rd_reg <= spr_mem[spr_addr_reg];
    end

    // Pattern memory
    always_ff @(posedge clk)
    begin
        if (data_wr && (tgt == SEL_PAT))
            pat_mem[bus_addr[vuri_pkg::PAT_AW-1:0]] <= item_reg.write_data;
        if (data_rd && (tgt == SEL_PAT))
            pat_rd_reg <= pat_mem[bus_addr[vuri_pkg::PAT_AW-1:0]];
    end

    // Nametable memory
    always_ff @(posedge clk)
    begin
        if (data_wr && (tgt == SEL_NT))
            nt_mem[nt_idx] <= item_reg.write_data;
        if (data_rd && (tgt == SEL_NT))
            nt_rd_reg <= nt_mem[nt_idx];
    end

    // Palette memory
    always_ff @(posedge clk)
    begin
        if (data_wr && (tgt == SEL_PAL))
            pal_mem[pal_idx] <= item_reg.write_data;
        if (data_rd && (tgt == SEL_PAL))
            pal_rd_reg <= pal_mem[pal_idx];
    end

    assign out_data = out_reg;

endmodule

// ===== sv/vuri_checker.sv =====
// Port-level checker for the video unit register interface, with its bind.
// Depends on vuri_pkg and video_unit_register_interface_assert.svh.
`include "video_unit_register_interface_assert.svh"

module vuri_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input vuri_pkg::out_item_t out_data
);

    // One item in flight: no transfer in the cycle after one
    `VURI_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)

    // An interrupt result never carries read data
    `VURI_ASSERT_IMP(a_nmi_no_data, out_valid && out_data.nmi_pulse, out_data.read_data == 8'd0)

    // Hold a stalled result
    `VURI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind video_unit_register_interface vuri_checker u_vuri_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/video_unit_register_interface_tb.sv =====
// Self-checking testbench for the video unit register interface.
// Drives CPU accesses and frame events, predicts every result in place.
// Depends on vuri_pkg and video_unit_register_interface.
`timescale 1ns / 100ps

module video_unit_register_interface_tb;

    localparam int unsigned NT_CELL    = vuri_pkg::PATTERN_BYTES;
    localparam int unsigned PAL_CELL   = vuri_pkg::PATTERN_BYTES
                                         + 2 * vuri_pkg::NAMETABLE_BYTES;
    localparam int unsigned CELL_COUNT = PAL_CELL + vuri_pkg::PALETTE_BYTES;
    localparam logic [13:0] NAMETABLE_START = 14'h2000;
    localparam int unsigned PHASE_ACCESSES  = 650;

    typedef struct packed {
        vuri_pkg::in_item_t  item;
        logic                typed;
        vuri_pkg::out_item_t want;
    } script_row_t;

    // Opening script: register extremes, events, aliasing, write-only reads
    localparam script_row_t OPENING_SCRIPT [0:24] = '{
        {vuri_pkg::REQ_READ,      vuri_pkg::REG_STATUS,  8'h00, 1'b1, 8'h00, 1'b0},
        {vuri_pkg::REQ_READ,      vuri_pkg::REG_CONTROL, 8'hFF, 1'b1, 8'h00, 1'b0},
        {vuri_pkg::REQ_VBLANK,    vuri_pkg::REG_DATA,    8'hFF, 1'b1, 8'h00, 1'b0},
        {vuri_pkg::REQ_READ,      vuri_pkg::REG_STATUS,  8'h00, 1'b1, 8'h80, 1'b0},
        {vuri_pkg::REQ_WRITE,     vuri_pkg::REG_CONTROL, 8'h84, 1'b0, 8'h00, 1'b0},
        {vuri_pkg::REQ_VBLANK,    vuri_pkg::REG_CONTROL, 8'h00, 1'b1, 8'h00, 1'b1},
        {vuri_pkg::REQ_WRITE,     vuri_pkg::REG_STATUS,  8'hFF, 1'b0, 8'h00, 1'b0},
        {vuri_pkg::REQ_PRERENDER, vuri_pkg::REG_SCROLL,  8'hFF, 1'b1, 8'h00, 1'b0},
        {vuri_pkg::REQ_READ,      vuri_pkg::REG_STATUS,  8'h00, 1'b1, 8'h00, 1'b0},
        {vuri_pkg::REQ_WRITE,     vuri_pkg::REG_MASK,    8'hFF, 1'b0, 8'h00, 1'b0},
        {vuri_pkg::REQ_WRITE,     vuri_pkg::REG_OAMADDR, 8'hFF, 1'b0, 8'h00, 1'b0},
        {vuri_pkg::REQ_WRITE,     vuri_pkg::REG_OAMDATA, 8'h5A, 1'b0, 8'h00, 1'b0},
        {vuri_pkg::REQ_READ,      vuri_pkg::REG_OAMDATA, 8'h00, 1'b1, 8'h5A, 1'b0},
        {vuri_pkg::REQ_WRITE,     vuri_pkg::REG_SCROLL,  8'hFF, 1'b0, 8'h00, 1'b0},
        {vuri_pkg::REQ_WRITE,     vuri_pkg::REG_SCROLL,  8'h00, 1'b0, 8'h00, 1'b0},
        {vuri_pkg::REQ_WRITE,     vuri_pkg::REG_ADDR,    8'h3F, 1'b0, 8'h00, 1'b0},
        {vuri_pkg::REQ_WRITE,     vuri_pkg::REG_ADDR,    8'h1C, 1'b0, 8'h00, 1'b0},
        {vuri_pkg::REQ_WRITE,     vuri_pkg::REG_DATA,    8'hC3, 1'b0, 8'h00, 1'b0},
        {vuri_pkg::REQ_READ,      vuri_pkg::REG_DATA,    8'h00, 1'b1, 8'hC3, 1'b0},
        {vuri_pkg::REQ_WRITE,     vuri_pkg::REG_CONTROL, 8'h00, 1'b0, 8'h00, 1'b0},
        {vuri_pkg::REQ_WRITE,     vuri_pkg::REG_ADDR,    8'h00, 1'b0, 8'h00, 1'b0},
        {vuri_pkg::REQ_WRITE,     vuri_pkg::REG_ADDR,    8'h00, 1'b0, 8'h00, 1'b0},
        {vuri_pkg::REQ_WRITE,     vuri_pkg::REG_DATA,    8'h00, 1'b0, 8'h00, 1'b0},
        {vuri_pkg::REQ_READ,      vuri_pkg::REG_ADDR,    8'hFF, 1'b1, 8'h00, 1'b0},
        {vuri_pkg::REQ_READ,      vuri_pkg::REG_SCROLL,  8'h00, 1'b1, 8'h00, 1'b0}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    vuri_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    vuri_pkg::out_item_t out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data = 1'b0;

    // Predicted register file state
    logic        mirror_horizontal = 1'b0;
    logic [7:0]  ctrl_reg = '0;
    logic [7:0]  mask_reg = '0;
    logic [2:0]  status_bits = '0;
    logic        second_write = 1'b0;
    logic [7:0]  fetch_buffer = '0;
    logic [15:0] vram_addr = '0;
    logic [15:0] vram_addr_tmp = '0;
    logic [2:0]  fine_x = '0;
    logic [7:0]  oam_addr = '0;
    bit   [7:0]  oam_bytes [vuri_pkg::SPRITE_MEM_BYTES];
    bit          oam_filled [vuri_pkg::SPRITE_MEM_BYTES];
    bit   [7:0]  vram_cells [CELL_COUNT];
    bit          cell_filled [CELL_COUNT];

    vuri_pkg::out_item_t results_due [$];
    vuri_pkg::out_item_t oldest_result;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned accesses_sent = 0;
    int unsigned results_checked = 0;
    int unsigned data_reads = 0;
    int unsigned nmi_count = 0;
    int unsigned error_count = 0;

    video_unit_register_interface dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Map a bus address to pattern, nametable or palette storage
    function automatic int unsigned bus_cell(input logic [15:0] addr);
        logic [13:0] a;
        logic [4:0]  p;
        logic        upper_table;
        a = addr[13:0];
        if (a < NAMETABLE_START)
            return int'(a[12:0]);
        if (a < vuri_pkg::PALETTE_BASE)
        begin
            upper_table = mirror_horizontal ? a[11] : a[10];
            return NT_CELL + (upper_table ? vuri_pkg::NAMETABLE_BYTES : 0) + int'(a[9:0]);
        end
        p = a[4:0];
        // Sprite backdrop entries fold onto the background ones
        if ((p & 5'h13) == 5'h10)
            p = p & 5'h0F;
        return PAL_CELL + int'(p);
    endfunction

    function automatic void step_vram_addr();
        vram_addr = vram_addr + (ctrl_reg[2] ? 16'd32 : 16'd1);
    endfunction

    // Apply one access to the predicted state and return its result
    function automatic vuri_pkg::out_item_t access_result(input vuri_pkg::in_item_t it);
        vuri_pkg::out_item_t res;
        logic [7:0]          d;
        int unsigned         slot;
        res = '0;
        d = it.write_data;
        case (it.req_type)
            vuri_pkg::REQ_READ:
            begin
                case (it.reg_addr)
                    vuri_pkg::REG_STATUS:
                    begin
                        res.read_data = {status_bits, fetch_buffer[4:0]};
                        status_bits[2] = 1'b0;
                        second_write = 1'b0;
                    end
                    vuri_pkg::REG_OAMDATA:
                        res.read_data = oam_bytes[oam_addr];
                    vuri_pkg::REG_DATA:
                    begin
                        res.read_data = fetch_buffer;
                        slot = bus_cell(vram_addr);
                        fetch_buffer = vram_cells[slot];
                        if (vram_addr[13:0] >= vuri_pkg::PALETTE_BASE)
                            res.read_data = fetch_buffer;
                        step_vram_addr();
                    end
                    default:
                        res.read_data = '0;
                endcase
            end
            vuri_pkg::REQ_WRITE:
            begin
                case (it.reg_addr)
                    vuri_pkg::REG_CONTROL:
                    begin
                        ctrl_reg = d;
                        vram_addr_tmp[11:10] = d[1:0];
                    end
                    vuri_pkg::REG_MASK:
                        mask_reg = d;
                    vuri_pkg::REG_OAMADDR:
                        oam_addr = d;
                    vuri_pkg::REG_OAMDATA:
                    begin
                        oam_bytes[oam_addr] = d;
                        oam_filled[oam_addr] = 1'b1;
                    end
                    vuri_pkg::REG_SCROLL:
                    begin
                        if (!second_write)
                        begin
                            fine_x = d[2:0];
                            vram_addr_tmp[4:0] = d[7:3];
                        end
                        else
                        begin
                            vram_addr_tmp[14:12] = d[2:0];
                            vram_addr_tmp[9:5] = d[7:3];
                        end
                        second_write = !second_write;
                    end
                    vuri_pkg::REG_ADDR:
                    begin
                        if (!second_write)
                            vram_addr_tmp = {2'b00, d[5:0], vram_addr_tmp[7:0]};
                        else
                        begin
                            vram_addr_tmp[7:0] = d;
                            vram_addr = vram_addr_tmp;
                        end
                        second_write = !second_write;
                    end
                    vuri_pkg::REG_DATA:
                    begin
                        slot = bus_cell(vram_addr);
                        vram_cells[slot] = d;
                        cell_filled[slot] = 1'b1;
                        step_vram_addr();
                    end
                    default:
                        ;
                endcase
            end
            vuri_pkg::REQ_VBLANK:
            begin
                status_bits[2] = 1'b1;
                res.nmi_pulse = ctrl_reg[7];
            end
            default:
                status_bits = '0;
        endcase
        return res;
    endfunction

    // A read may only land on storage that has been written
    function automatic bit read_is_safe(input vuri_pkg::in_item_t it);
        if (it.req_type != vuri_pkg::REQ_READ)
            return 1'b1;
        if (it.reg_addr == vuri_pkg::REG_OAMDATA)
            return oam_filled[oam_addr];
        if (it.reg_addr == vuri_pkg::REG_DATA)
            return cell_filled[bus_cell(vram_addr)];
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    // High address byte, weighted toward each memory region
    function automatic logic [7:0] pick_addr_high();
        logic [5:0] page;
        case ($urandom_range(3))
            0: page = 6'($urandom_range(8'h1F));
            1: page = 6'($urandom_range(8'h3E, 8'h20));
            2: page = 6'h3F;
            default: page = 6'($urandom_range(8'h3F));
        endcase
        return {2'($urandom_range(3)), page};
    endfunction

    // Present one access, wait for the transfer, record its result
    task automatic send_access(input vuri_pkg::in_item_t it, input bit typed,
                               input vuri_pkg::out_item_t want);
        vuri_pkg::out_item_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        // Turn reads of unwritten storage into writes of the same register
        if (!read_is_safe(it))
            it.req_type = vuri_pkg::REQ_WRITE;
        in_valid = 1'b1;
        in_data = it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = access_result(it);
        results_due.push_back(typed ? want : predicted);
        accesses_sent++;
        if (it.req_type == vuri_pkg::REQ_READ && it.reg_addr == vuri_pkg::REG_DATA)
            data_reads++;
        if (predicted.nmi_pulse)
            nmi_count++;
    endtask

    task automatic issue(input logic [1:0] req, input logic [2:0] regno, input logic [7:0] d);
        send_access({req, regno, d}, 1'b0, '0);
    endtask

    // Clear the write latch, then load the VRAM address in two writes
    task automatic point_at(input logic [7:0] high, input logic [7:0] low);
        issue(vuri_pkg::REQ_READ, vuri_pkg::REG_STATUS, rand_byte());
        issue(vuri_pkg::REQ_WRITE, vuri_pkg::REG_ADDR, high);
        issue(vuri_pkg::REQ_WRITE, vuri_pkg::REG_ADDR, low);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mirror_mode(input logic mode);
        @(negedge clk);
        in_valid = 1'b0;
        cfg_valid = 1'b1;
        cfg_data = mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mirror_horizontal = mode;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly well-formed access sequences with random content, some noise
    task automatic run_random_phase(input int unsigned budget);
        int unsigned first_count;
        int unsigned kind;
        int unsigned burst;
        logic [7:0]  high;
        logic [7:0]  low;
        first_count = accesses_sent;
        while (accesses_sent - first_count < budget)
        begin
            kind = $urandom_range(99);
            if (kind < 15)
                point_at(pick_addr_high(), rand_byte());
            else if (kind < 35)
            begin
                high = pick_addr_high();
                low = rand_byte();
                burst = $urandom_range(6, 1);
                point_at(high, low);
                repeat (burst)
                    issue(vuri_pkg::REQ_WRITE, vuri_pkg::REG_DATA, rand_byte());
                point_at(high, low);
                repeat (burst + 1)
                    issue(vuri_pkg::REQ_READ, vuri_pkg::REG_DATA, rand_byte());
            end
            else if (kind < 45)
                issue(vuri_pkg::REQ_WRITE, vuri_pkg::REG_CONTROL, rand_byte());
            else if (kind < 55)
            begin
                issue(vuri_pkg::REQ_WRITE, vuri_pkg::REG_OAMADDR, rand_byte());
                issue(vuri_pkg::REQ_WRITE, vuri_pkg::REG_OAMDATA, rand_byte());
                issue(vuri_pkg::REQ_READ, vuri_pkg::REG_OAMDATA, rand_byte());
            end
            else if (kind < 62)
            begin
                issue(vuri_pkg::REQ_WRITE, vuri_pkg::REG_SCROLL, rand_byte());
                issue(vuri_pkg::REQ_WRITE, vuri_pkg::REG_SCROLL, rand_byte());
            end
            else if (kind < 72)
            begin
                issue($urandom_range(1) ? vuri_pkg::REQ_VBLANK : vuri_pkg::REQ_PRERENDER,
                      3'($urandom_range(7)), rand_byte());
                issue(vuri_pkg::REQ_READ, vuri_pkg::REG_STATUS, rand_byte());
            end
            else if (kind < 80)
            begin
                repeat ($urandom_range(4, 1))
                    issue(vuri_pkg::REQ_READ, vuri_pkg::REG_DATA, rand_byte());
            end
            else
                issue(2'($urandom_range(3)), 3'($urandom_range(7)), rand_byte());
            // Now and then hold off until every result is back
            if ($urandom_range(49) == 0)
                wait_results_drained();
        end
    endtask

    // Stall the result side at random
    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected result: read_data %h nmi_pulse %b",
                         $time, out_data.read_data, out_data.nmi_pulse);
                error_count++;
            end
            else
            begin
                oldest_result = results_due.pop_front();
                results_checked++;
                if (out_data.read_data !== oldest_result.read_data)
                begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, oldest_result.read_data, out_data.read_data);
                    error_count++;
                end
                if (out_data.nmi_pulse !== oldest_result.nmi_pulse)
                begin
                    $display("%0t: nmi_pulse expected %b actual %b",
                             $time, oldest_result.nmi_pulse, out_data.nmi_pulse);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the opening script with vertical mirroring
        write_mirror_mode(1'b0);
        foreach (OPENING_SCRIPT[i])
            send_access(OPENING_SCRIPT[i].item, OPENING_SCRIPT[i].typed,
                        OPENING_SCRIPT[i].want);

        // Sender idles less than the receiver, horizontal mirroring
        wait_results_drained();
        write_mirror_mode(1'b1);
        send_idle_pct = 26;
        recv_idle_pct = 46;
        run_random_phase(PHASE_ACCESSES);

        // Swap the idle rates, back to vertical mirroring
        wait_results_drained();
        write_mirror_mode(1'b0);
        send_idle_pct = 46;
        recv_idle_pct = 26;
        run_random_phase(PHASE_ACCESSES);

        // Full rate on both sides, horizontal mirroring
        wait_results_drained();
        write_mirror_mode(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(PHASE_ACCESSES);

        wait_results_drained();
        repeat (6)
            @(posedge clk);
        $display("Drove %0d accesses over both mirror modes and three idle patterns;",
                 accesses_sent);
        $display("checked %0d results, %0d data-port reads, %0d interrupt pulses.",
                 results_checked, data_reads, nmi_count);
        if (error_count == 0)
            $display("video_unit_register_interface_tb: clean");
        else
            $display("video_unit_register_interface_tb: errors");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5_000_000;
        $display("video_unit_register_interface_tb: errors");
        $finish;
    end

endmodule
